// ----- hw/rtl/kcs_pkg.sv -----
// Shared types, constants and helper functions for the Khmer cluster segmenter.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package kcs_pkg;

	localparam logic [20:0] COENG_CP   = 21'h017D2;
	localparam logic [20:0] BASE_LO    = 21'h01780;
	localparam logic [20:0] BASE_HI    = 21'h017B3;
	localparam logic [20:0] CONS_HI    = 21'h017A2;
	localparam logic [20:0] SIGN_LO    = 21'h017B6;
	localparam logic [20:0] SIGN_HI    = 21'h017D1;
	localparam logic [20:0] SIGN_NIKA  = 21'h017D3;
	localparam logic [20:0] SIGN_ATTH  = 21'h017DD;
	localparam logic [8:0]  COUNT_CAP  = 9'd256;
	localparam int          BATCH_MAX  = 6;
	localparam int          BUF_DEPTH  = 7;

	// one decoded codepoint with its byte length (1..4)
	typedef struct packed {
		logic [20:0] cp;
		logic [2:0]  len;
		logic        vld;
	} token_t;

	typedef token_t [2:0] tok_vec_t;

	// one result transaction
	typedef struct packed {
		logic [7:0]  bytes;
		logic [20:0] cp;
		logic        base;
		logic        sat;
		logic        last;
	} emit_t;

	typedef struct packed {
		logic        open;
		logic [8:0]  count;
		logic [20:0] first_cp;
		logic        coeng;
		logic [2:0]  coeng_bytes;
	} clu_state_t;

	typedef struct packed {
		clu_state_t     st;
		emit_t [2:0]    em;
		logic [1:0]     n;
	} take_t;

	typedef struct packed {
		emit_t [BATCH_MAX-1:0] em;
		logic [2:0]            n;
	} batch_t;

	function automatic logic [2:0] seq_len(logic [7:0] c);
		if (!c[7])                 return 3'd1;
		else if (c[7:5] == 3'b110)   return 3'd2;
		else if (c[7:4] == 4'b1110)  return 3'd3;
		else if (c[7:3] == 5'b11110) return 3'd4;
		else                         return 3'd1;
	endfunction

	function automatic logic [20:0] lead_bits(logic [7:0] c, logic [2:0] n);
		case (n)
			3'd2:    return {10'b0, c[4:0], 6'b0};
			3'd3:    return {5'b0, c[3:0], 12'b0};
			default: return {c[2:0], 18'b0};
		endcase
	endfunction

	// lone byte: ASCII passes, anything else decodes to zero
	function automatic logic [20:0] single_cp(logic [7:0] c);
		return c[7] ? 21'd0 : {13'b0, c};
	endfunction

	function automatic logic is_base(logic [20:0] cp);
		return (cp >= BASE_LO) && (cp <= BASE_HI);
	endfunction

	function automatic logic is_cons(logic [20:0] cp);
		return (cp >= BASE_LO) && (cp <= CONS_HI);
	endfunction

	function automatic logic is_sign(logic [20:0] cp);
		return ((cp >= SIGN_LO) && (cp <= SIGN_HI)) || (cp == SIGN_NIKA) || (cp == SIGN_ATTH);
	endfunction

	function automatic logic [8:0] add_sat(logic [8:0] cnt, logic [3:0] n);
		logic [9:0] sum;
		sum = {1'b0, cnt} + {6'b0, n};
		return (sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : sum[8:0];
	endfunction

	// count is at most 256, so bit 8 alone marks saturation
	function automatic emit_t mk_emit(logic [8:0] b, logic [20:0] cp, logic base);
		emit_t e;
		e.bytes = b[8] ? 8'hFF : b[7:0];
		e.cp    = cp;
		e.base  = base;
		e.sat   = b[8];
		e.last  = 1'b0;
		return e;
	endfunction

	function automatic take_t close_open(clu_state_t st);
		take_t r;
		r = '0;
		if (st.open) begin
			r.em[r.n] = mk_emit(st.count, st.first_cp, 1'b1);
			r.n = r.n + 2'd1;
		end
		if (st.coeng) begin
			r.em[r.n] = mk_emit({6'b0, st.coeng_bytes}, COENG_CP, 1'b0);
			r.n = r.n + 2'd1;
		end
		return r;
	endfunction

	function automatic take_t take_cp(clu_state_t st, logic [20:0] cp, logic [2:0] len);
		take_t r;
		logic  start;
		r.st  = st;
		r.em  = '0;
		r.n   = 2'd0;
		start = 1'b0;
		if (st.coeng) begin
			if (is_cons(cp)) begin
				r.st.count       = add_sat(st.count, {1'b0, st.coeng_bytes} + {1'b0, len});
				r.st.coeng       = 1'b0;
				r.st.coeng_bytes = 3'd0;
			end else begin
				r     = close_open(st);
				start = 1'b1;
			end
		end else if (st.open) begin
			if (cp == COENG_CP) begin
				r.st.coeng       = 1'b1;
				r.st.coeng_bytes = len;
			end else if (is_sign(cp)) begin
				r.st.count = add_sat(st.count, {1'b0, len});
			end else begin
				r     = close_open(st);
				start = 1'b1;
			end
		end else begin
			start = 1'b1;
		end
		if (start) begin
			if (is_base(cp)) begin
				r.st.open     = 1'b1;
				r.st.count    = {6'b0, len};
				r.st.first_cp = cp;
			end else begin
				r.em[r.n] = mk_emit({6'b0, len}, cp, 1'b0);
				r.n = r.n + 2'd1;
			end
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/kcs_utf8_dec.sv -----
// UTF-8 byte decoder: length masks only, truncated tail re-decoded at end of text.
// Depends on kcs_pkg. Emits up to three codepoint tokens per byte.
`timescale 1ns / 1ps

module kcs_utf8_dec (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        text_byte,
	input  logic              eot,
	output kcs_pkg::tok_vec_t tok
);
	import kcs_pkg::*;

	logic [1:0]  exp_q, exp_n;
	logic [20:0] part_q, part_n, part_or;
	logic [7:0]  p0_q, p1_q, p2_q, p0_n, p1_n, p2_n;
	logic [2:0]  n_b, n_p, have, m;

	always_comb begin
		tok    = '0;
		exp_n  = exp_q;
		part_n = part_q;
		p0_n   = p0_q;
		p1_n   = p1_q;
		p2_n   = p2_q;
		n_b    = seq_len(text_byte);
		n_p    = seq_len(p0_q);
		have   = n_p - {1'b0, exp_q};
		m      = 3'd0;
		case (exp_q)
			2'd1:    part_or = part_q | {15'b0, text_byte[5:0]};
			2'd2:    part_or = part_q | {9'b0, text_byte[5:0], 6'b0};
			default: part_or = part_q | {3'b0, text_byte[5:0], 12'b0};
		endcase

		if (exp_q == 2'd0) begin
			if (n_b == 3'd1) begin
				tok[0] = '{cp: single_cp(text_byte), len: 3'd1, vld: 1'b1};
			end else begin
				p0_n   = text_byte;
				exp_n  = 2'(n_b - 3'd1);
				part_n = lead_bits(text_byte, n_b);
			end
		end else begin
			exp_n = exp_q - 2'd1;
			if (exp_n == 2'd0) begin
				tok[0] = '{cp: part_or, len: n_p, vld: 1'b1};
				part_n = '0;
			end else begin
				part_n = part_or;
				if (have == 3'd1) p1_n = text_byte;
				else              p2_n = text_byte;
			end
		end

		// text ends inside a sequence: cut lead gives zero, rest re-decoded as leads
		if (eot && (exp_n != 2'd0)) begin
			m      = seq_len(p0_n) - {1'b0, exp_n};
			tok[0] = '{cp: 21'd0, len: 3'd1, vld: 1'b1};
			if (m == 3'd3 && seq_len(p1_n) == 3'd2) begin
				tok[1] = '{cp: lead_bits(p1_n, 3'd2) | {15'b0, p2_n[5:0]}, len: 3'd2,
					vld: 1'b1};
			end else begin
				if (m >= 3'd2) tok[1] = '{cp: single_cp(p1_n), len: 3'd1, vld: 1'b1};
				if (m == 3'd3) tok[2] = '{cp: single_cp(p2_n), len: 3'd1, vld: 1'b1};
			end
		end
		if (eot) begin
			exp_n  = 2'd0;
			part_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= '0;
			part_q <= '0;
		end else if (fire) begin
			exp_q  <= exp_n;
			part_q <= part_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			p0_q <= p0_n;
			p1_q <= p1_n;
			p2_q <= p2_n;
		end
	end

endmodule

// ----- hw/rtl/kcs_cluster.sv -----
// Cluster former: applies decoded tokens to the open-cluster state, builds result batch.
// Depends on kcs_pkg. At most six results per input byte.
`timescale 1ns / 1ps

module kcs_cluster (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  kcs_pkg::tok_vec_t tok,
	input  logic              eot,
	output kcs_pkg::batch_t   batch
);
	import kcs_pkg::*;

	clu_state_t st_q, st_n;

	always_comb begin
		take_t      t;
		clu_state_t st;
		logic [2:0] idx;
		batch_t     b;
		st  = st_q;
		idx = 3'd0;
		b   = '0;
		t   = '0;
		for (int i = 0; i < 3; i++) begin
			if (tok[i].vld) begin
				t  = take_cp(st, tok[i].cp, tok[i].len);
				st = t.st;
				for (int j = 0; j < 3; j++) begin
					if (2'(j) < t.n && idx < 3'(BATCH_MAX)) begin
						b.em[idx] = t.em[j];
						idx = idx + 3'd1;
					end
				end
			end
		end
		if (eot) begin
			t  = close_open(st);
			st = t.st;
			for (int j = 0; j < 2; j++) begin
				if (2'(j) < t.n && idx < 3'(BATCH_MAX)) begin
					b.em[idx] = t.em[j];
					idx = idx + 3'd1;
				end
			end
			if (idx != 3'd0) b.em[idx - 3'd1].last = 1'b1;
		end
		b.n   = idx;
		batch = b;
		st_n  = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_n;
		end
	end

endmodule

// ----- hw/rtl/kcs_out_buf.sv -----
// Result shift buffer: takes a whole batch when at most one entry is left; drains one a cycle if ready.
// Depends on kcs_pkg.
`timescale 1ns / 1ps

module kcs_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  kcs_pkg::batch_t batch,
	output logic            can_load,
	output logic            out_valid,
	input  logic            out_ready,
	output kcs_pkg::emit_t  out_head
);
	import kcs_pkg::*;

	emit_t      ent_q [BUF_DEPTH];
	emit_t      sh    [BUF_DEPTH];
	emit_t      nxt   [BUF_DEPTH];
	logic [2:0] cnt_q, cnt_after, cnt_n;
	logic       drain;

	assign out_valid = (cnt_q != 3'd0);
	assign out_head  = ent_q[0];
	assign drain     = out_valid && out_ready;
	assign can_load  = (cnt_q <= 3'd1);
	assign cnt_after = cnt_q - {2'b0, drain};

	always_comb begin
		for (int j = 0; j < BUF_DEPTH - 1; j++) sh[j] = drain ? ent_q[j+1] : ent_q[j];
		sh[BUF_DEPTH-1] = ent_q[BUF_DEPTH-1];
		for (int j = 0; j < BUF_DEPTH; j++) nxt[j] = sh[j];
		cnt_n = cnt_after;
		if (load) begin
			if (cnt_after == 3'd0) begin
				for (int j = 0; j < BATCH_MAX; j++) nxt[j] = batch.em[j];
			end else begin
				for (int j = 1; j < BUF_DEPTH; j++) nxt[j] = batch.em[j-1];
			end
			cnt_n = cnt_after + batch.n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < BUF_DEPTH; j++) ent_q[j] <= nxt[j];
	end

endmodule

// ----- hw/rtl/khmer_cluster_segmenter.sv -----
// Top level of the Khmer cluster segmenter: input register, decoder, cluster former,
// result buffer. Depends on kcs_pkg, kcs_utf8_dec, kcs_cluster, kcs_out_buf.
`timescale 1ns / 1ps

// Takes UTF-8 text one byte per transaction (s_tlast marks the final byte of a text)
// and returns one transaction per Khmer syllable cluster: its byte count (saturating
// at 255 with a flag), its first codepoint and whether it opens on a base character.
// Decoding uses length masks only; bad lead bytes give codepoint 0, and a sequence cut
// short by the end of text is re-decoded byte by byte. A coeng is held back until the
// next codepoint shows whether it joins the cluster, so a cluster is reported only once
// the following codepoint (or the end of text) closes it. With an empty result buffer
// the results of a byte pass through the input register and the result buffer before
// they are presented. A byte is taken every cycle as long as the result buffer holds
// at most one pending result; a byte may yield up to six results at end of text and
// up to three otherwise, and they leave one by one through the single result port.
// After the end-of-text byte all state returns to reset and the next byte starts a
// new text. No clearing pass after reset.
module khmer_cluster_segmenter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] cluster_len, [28:8] first_codepoint, [31:29] zero
	output logic [1:0]  m_tuser,   // [0] starts_with_base, [1] length_saturated
	output logic        m_tlast    // last_cluster
);
	import kcs_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       s_fire, fire, can_load;
	tok_vec_t   tok;
	batch_t     batch;
	emit_t      head;

	// input register; processing fires when the result buffer can take a full batch
	assign s_fire   = s_tvalid && s_tready;
	assign fire     = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_fire || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	kcs_utf8_dec u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.text_byte (byte_s1),
		.eot       (eot_s1),
		.tok       (tok)
	);

	kcs_cluster u_clu (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.tok    (tok),
		.eot    (eot_s1),
		.batch  (batch)
	);

	kcs_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.batch     (batch),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_head  (head)
	);

	assign m_tdata = {3'b0, head.cp, head.bytes};
	assign m_tuser = {head.sat, head.base};
	assign m_tlast = head.last;

endmodule

// ----- dv/tb_khmer_cluster_segmenter.sv -----
// Self-checking testbench for khmer_cluster_segmenter: streams UTF-8 text bytes, predicts
// the cluster transactions with a local segmentation model and checks them in order.
// Depends on kcs_pkg (code point constants) and the RTL under hw/rtl.
`timescale 1ns / 1ps

module tb_khmer_cluster_segmenter;

	localparam int CYCLE_LIMIT = 200000;

	// one expected cluster transaction
	typedef struct {
		logic [7:0]  nbytes;
		logic [20:0] cp;
		logic        base;
		logic        sat;
		logic        last;
	} cluster_rec_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] text_byte
	logic        s_tlast  = 1'b0;    // end_of_text
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;            // [7:0] cluster_len, [28:8] first_codepoint
	logic [1:0]  m_tuser;            // [0] starts_with_base, [1] length_saturated
	logic        m_tlast;            // last_cluster

	khmer_cluster_segmenter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Segmentation model: decoder state plus the open cluster
	// ------------------------------------------------------------------
	logic [7:0]   seq_buf [3] = '{8'h00, 8'h00, 8'h00};  // bytes of the unfinished sequence
	int           seq_need  = 0;                        // continuation bytes still missing
	logic [20:0]  seq_acc   = '0;                       // code point bits gathered so far
	logic         clu_open  = 1'b0;
	int           clu_count = 0;                        // saturates at 256
	logic [20:0]  clu_first = '0;
	logic         coeng_wait = 1'b0;                    // coeng after the cluster, undecided
	int           coeng_len = 0;

	cluster_rec_t step_out [kcs_pkg::BATCH_MAX];
	int           step_n;
	cluster_rec_t pending_clusters [$];

	int  sent_items = 0;
	int  errors     = 0;
	int  cycle_count = 0;
	bit  sender_idles = 1'b0;
	bit  rx_stalls    = 1'b0;

	function automatic int utf8_span(logic [7:0] c);
		if (c < 8'h80)               return 1;
		if ((c & 8'hE0) == 8'hC0)    return 2;
		if ((c & 8'hF0) == 8'hE0)    return 3;
		if ((c & 8'hF8) == 8'hF0)    return 4;
		return 1;
	endfunction

	function automatic logic [20:0] lead_payload(logic [7:0] c, int n);
		logic [20:0] w;
		w = 21'(c);
		if (n == 2) return (w & 21'h1F) << 6;
		if (n == 3) return (w & 21'h0F) << 12;
		return (w & 21'h07) << 18;
	endfunction

	// a byte standing alone: ASCII passes, anything else is undecodable
	function automatic logic [20:0] lone_cp(logic [7:0] c);
		return c[7] ? 21'd0 : 21'(c);
	endfunction

	function automatic bit khmer_base(logic [20:0] cp);
		return cp >= kcs_pkg::BASE_LO && cp <= kcs_pkg::BASE_HI;
	endfunction

	function automatic bit khmer_cons(logic [20:0] cp);
		return cp >= kcs_pkg::BASE_LO && cp <= kcs_pkg::CONS_HI;
	endfunction

	function automatic bit khmer_sign(logic [20:0] cp);
		return (cp >= kcs_pkg::SIGN_LO && cp <= kcs_pkg::SIGN_HI) ||
			cp == kcs_pkg::SIGN_NIKA || cp == kcs_pkg::SIGN_ATTH;
	endfunction

	function automatic void note_cluster(int nbytes, logic [20:0] cp, logic base);
		cluster_rec_t r;
		if (step_n >= kcs_pkg::BATCH_MAX) return;
		r.nbytes = (nbytes > 255) ? 8'hFF : 8'(nbytes);
		r.cp     = cp;
		r.base   = base;
		r.sat    = (nbytes > 255);
		r.last   = 1'b0;
		step_out[step_n] = r;
		step_n++;
	endfunction

	function automatic void grow_cluster(int n);
		clu_count += n;
		if (clu_count > int'(kcs_pkg::COUNT_CAP)) clu_count = int'(kcs_pkg::COUNT_CAP);
	endfunction

	function automatic void flush_cluster();
		if (clu_open) note_cluster(clu_count, clu_first, 1'b1);
		if (coeng_wait) note_cluster(coeng_len, kcs_pkg::COENG_CP, 1'b0);
		clu_open   = 1'b0;
		coeng_wait = 1'b0;
		clu_count  = 0;
		clu_first  = '0;
		coeng_len  = 0;
	endfunction

	// one decoded code point into the cluster former
	function automatic void absorb(logic [20:0] cp, int len);
		if (coeng_wait) begin
			if (khmer_cons(cp)) begin
				grow_cluster(coeng_len + len);
				coeng_wait = 1'b0;
				coeng_len  = 0;
				return;
			end
			flush_cluster();
		end else if (clu_open) begin
			if (cp == kcs_pkg::COENG_CP) begin
				coeng_wait = 1'b1;
				coeng_len  = len;
				return;
			end
			if (khmer_sign(cp)) begin
				grow_cluster(len);
				return;
			end
			flush_cluster();
		end
		if (khmer_base(cp)) begin
			clu_open  = 1'b1;
			clu_count = len;
			clu_first = cp;
		end else begin
			note_cluster(len, cp, 1'b0);
		end
	endfunction

	// text ended inside a sequence: walk the gathered bytes again as fresh leads
	function automatic void rescan_tail(int m);
		int          pos;
		int          n;
		logic [20:0] cp;
		pos = 0;
		while (pos < m) begin
			n = utf8_span(seq_buf[pos]);
			if (n == 1) begin
				absorb(lone_cp(seq_buf[pos]), 1);
				pos += 1;
			end else if (pos + n <= m) begin
				cp = lead_payload(seq_buf[pos], n);
				for (int k = 1; k < n; k++)
					cp |= (21'(seq_buf[pos + k]) & 21'h3F) << (6 * (n - 1 - k));
				absorb(cp, n);
				pos += n;
			end else begin
				absorb(21'd0, 1);
				pos += 1;
			end
		end
	endfunction

	// expected clusters caused by one accepted byte
	function automatic void segment_byte(logic [7:0] b, logic eot);
		int n;
		int have;
		int m;
		step_n = 0;
		if (seq_need == 0) begin
			n = utf8_span(b);
			if (n == 1) begin
				absorb(lone_cp(b), 1);
			end else begin
				seq_buf[0] = b;
				seq_need   = n - 1;
				seq_acc    = lead_payload(b, n);
			end
		end else begin
			n    = utf8_span(seq_buf[0]);
			have = n - seq_need;
			seq_acc |= (21'(b) & 21'h3F) << (6 * (seq_need - 1));
			seq_need--;
			if (seq_need == 0) begin
				absorb(seq_acc, n);
				seq_acc = '0;
			end else if (have < 3) begin
				seq_buf[have] = b;
			end
		end
		if (eot) begin
			if (seq_need != 0) begin
				m = utf8_span(seq_buf[0]) - seq_need;
				if (m > 3) m = 3;
				rescan_tail(m);
			end
			flush_cluster();
			if (step_n > 0) step_out[step_n - 1].last = 1'b1;
			seq_need = 0;
			seq_acc  = '0;
		end
		for (int i = 0; i < step_n; i++) pending_clusters.push_back(step_out[i]);
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// One byte transaction. The optional idle burst comes before driving, so tvalid
	// never sees two assignments in one step. The byte is predicted as soon as it is
	// on the bus: it can't be withdrawn and no result of it can appear before acceptance.
	task automatic push_byte(input logic [7:0] b, input logic eot);
		if (sender_idles && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eot;
		segment_byte(b, eot);
		sent_items++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Encode a code point; cut > 0 sends only that many leading bytes.
	// end_of_text rides on the last byte actually sent.
	task automatic send_cp(input logic [20:0] cp, input logic eot, input int cut = 0);
		logic [7:0] enc [4];
		int         n;
		if (cp < 21'h80) begin
			enc[0] = cp[7:0];
			n = 1;
		end else if (cp < 21'h800) begin
			enc[0] = {3'b110, cp[10:6]};
			enc[1] = {2'b10, cp[5:0]};
			n = 2;
		end else if (cp < 21'h10000) begin
			enc[0] = {4'b1110, cp[15:12]};
			enc[1] = {2'b10, cp[11:6]};
			enc[2] = {2'b10, cp[5:0]};
			n = 3;
		end else begin
			enc[0] = {5'b11110, cp[20:18]};
			enc[1] = {2'b10, cp[17:12]};
			enc[2] = {2'b10, cp[11:6]};
			enc[3] = {2'b10, cp[5:0]};
			n = 4;
		end
		if (cut > 0 && cut < n) n = cut;
		for (int i = 0; i < n; i++) push_byte(enc[i], eot && (i == n - 1));
	endtask

	// Hold the sender until every expected cluster has come back; always drops
	// tvalid before waiting, so the next drive lands in a later step.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_clusters.size() != 0) @(posedge clk);
	endtask

	function automatic logic [20:0] random_sign();
		case ($urandom_range(0, 5))
			0:       return kcs_pkg::SIGN_NIKA;
			1:       return kcs_pkg::SIGN_ATTH;
			default: return kcs_pkg::SIGN_LO + 21'($urandom_range(0, 27));
		endcase
	endfunction

	// Weighted toward Khmer consonants, coengs and signs so clusters grow deep.
	function automatic logic [20:0] random_cp();
		case ($urandom_range(0, 13))
			0, 1, 2, 3: return kcs_pkg::BASE_LO + 21'($urandom_range(0, 34));
			4:          return 21'h17A3 + 21'($urandom_range(0, 16));   // independent vowels
			5, 6, 7:    return kcs_pkg::COENG_CP;
			8, 9:       return random_sign();
			10: begin
				// Khmer block neighbors that belong to no cluster class
				case ($urandom_range(0, 4))
					0:       return 21'h177F;
					1:       return 21'h17B4 + 21'($urandom_range(0, 1));
					2:       return 21'h17D4 + 21'($urandom_range(0, 8));
					3:       return 21'h17DE;
					default: return 21'h17E0 + 21'($urandom_range(0, 31));
				endcase
			end
			11:         return 21'($urandom_range(1, 127));
			12:         return 21'($urandom_range(21'h80, 21'hFFFF));
			default:    return 21'($urandom_range(21'h10000, 21'h1FFFFF));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Byte extremes, bad lead bytes and a 4-byte lead followed by bytes that
	// are mostly not continuation bytes (only masked, never checked).
	task automatic test_lone_bytes();
		push_byte(8'h01, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hF7, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hC0, 1'b1);
	endtask

	// Base, coeng joined by a consonant, then a coeng followed by a sign:
	// the sign is no consonant, so the cluster closes and the coeng stands alone.
	task automatic test_coeng_cluster();
		send_cp(kcs_pkg::BASE_LO, 1'b0);
		send_cp(kcs_pkg::COENG_CP, 1'b0);
		send_cp(21'h179F, 1'b0);
		send_cp(kcs_pkg::COENG_CP, 1'b0);
		send_cp(kcs_pkg::SIGN_LO, 1'b1);
	endtask

	// Text cut inside a 4-byte sequence: the lead decodes to 0 and the
	// remaining bytes are decoded again as a 2-byte sequence.
	task automatic test_truncated_tail();
		push_byte(8'hF0, 1'b0);
		push_byte(8'hC3, 1'b0);
		push_byte(8'hA9, 1'b1);
	endtask

	// One cluster of 258 bytes, just past 255, so the count saturates.
	task automatic test_long_cluster();
		send_cp(21'h1781, 1'b0);
		for (int i = 0; i < 83; i++) begin
			if (i == 40) begin
				send_cp(kcs_pkg::COENG_CP, 1'b0);
				send_cp(kcs_pkg::CONS_HI, 1'b0);
			end
			send_cp(random_sign(), i == 82);
		end
	endtask

	// Random texts: mostly well-formed code points, some stray bytes, and
	// sequences cut short either mid-text or right at the end of the text.
	task automatic test_random_text(input int item_goal);
		int stop_at;
		int units;
		bit eot;
		stop_at = sent_items + item_goal;
		while (sent_items < stop_at) begin
			units = $urandom_range(1, 10);
			for (int u = 0; u < units; u++) begin
				eot = (u == units - 1);
				case ($urandom_range(0, 15))
					0:       push_byte(8'($urandom_range(1, 255)), eot);
					1:       send_cp(random_cp(), eot, $urandom_range(1, 3));
					default: send_cp(random_cp(), eot);
				endcase
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver side: ready stalls in random bursts of idle cycles
	// ------------------------------------------------------------------
	int stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Each result transaction against the oldest expectation.
	always @(posedge clk) begin
		cluster_rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_clusters.size() == 0) begin
				$display("%0t: unexpected cluster bytes=%0d cp=%h user=%b last=%b", $time,
					m_tdata[7:0], m_tdata[28:8], m_tuser, m_tlast);
				errors++;
			end else begin
				want = pending_clusters.pop_front();
				if (m_tdata !== {3'b000, want.cp, want.nbytes} ||
					m_tuser !== {want.sat, want.base} || m_tlast !== want.last) begin
					$display("%0t: expected bytes=%0d cp=%h base=%b sat=%b last=%b",
						$time, want.nbytes, want.cp, want.base, want.sat, want.last);
					$display("%0t: got      bytes=%0d cp=%h base=%b sat=%b last=%b pad=%b",
						$time, m_tdata[7:0], m_tdata[28:8], m_tuser[0], m_tuser[1],
						m_tlast, m_tdata[31:29]);
					errors++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		sender_idles = 1'b1;
		rx_stalls    = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		test_lone_bytes();
		test_coeng_cluster();
		test_truncated_tail();
		wait_for_results();
		test_long_cluster();
		wait_for_results();
		test_random_text(40);
		wait_for_results();
		// closing stretch runs back to back on both sides
		sender_idles = 1'b0;
		rx_stalls    = 1'b0;
		test_random_text(20);

		wait_for_results();
		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
